// File: rtl/core/wspwm_pkg.sv
// Shared constants, codes and helpers for the WS2812 PWM slot encoder.
// No dependencies; imported by the top level.
package wspwm_pkg;

  localparam int LED_SLOTS   = 128;  // LEDs sent per frame
  localparam int HALF_WORDS  = 24;   // compare words per fill
  localparam int RESET_SLOTS = 2;    // all-zero fills at frame start
  localparam int STORE_DEPTH = 128;  // colour store entries
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = 8;
  localparam int WORD_W      = 6;
  localparam int COUNT_W     = $clog2(HALF_WORDS);
  localparam int CMP_W       = 16;
  localparam int SCALE_W     = 9;
  localparam int COLOUR_W    = 24;

  localparam logic [SCALE_W-1:0] SCALE_FULL = SCALE_W'(256);

  // Item kinds carried in tuser
  localparam logic OP_COLOUR = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_PULSE_HIGH = 2'd0;
  localparam logic [1:0] REG_PULSE_LOW  = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

  // (c * scale) >> 8 with scale clamped to full brightness
  function automatic logic [7:0] scale_channel(input logic [7:0] c,
                                               input logic [SCALE_W-1:0] scale);
    logic [SCALE_W-1:0] s;
    logic [15:0]        p;
    s = (scale > SCALE_FULL) ? SCALE_FULL : scale;
    p = {8'd0, c} * {7'd0, s};
    return p[15:8];
  endfunction

endpackage

// File: rtl/core/wspwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wspwm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ws2812_pwm_slot_encoder.sv
// WS2812 PWM slot encoder top level: colour store, slot counter, bit serializer.
// Depends on wspwm_pkg and wspwm_ram.
//
// Usage:
//   s_axis carries two kinds of item, selected by tuser. A colour item stores
//   one LED's red/green/blue at led_index and gives no output; it is taken in
//   any cycle outside reset. A fill item names the DMA half just sent and yields
//   24 timer compare words on m_axis for the other half, tlast on the 24th.
//   The first two fills of a frame are all-zero reset slots; each later fill
//   sends the next LED, brightness-scaled, green/red/blue MSB first.
//   Pipeline: a taken fill reads the colour store into the fetch stage; it is
//   scaled and loaded into the output register once the serializer is free.
//   Words then stream one per cycle while m_axis is ready, and a fill holds the
//   serializer until its last word is taken; that serializer sets the fill rate.
//   One more fill can wait in the fetch stage, so the next fill is taken
//   while the current one is still streaming.
//   When m_axis stalls the current word holds; once the fetch stage is full
//   further fills wait (tready low for fills), colour items still go in.
//   Reset: s_axis tready low, slot counter to the first reset slot, registers
//   to defaults (58, 29, 256), colour store reads as zero through per-entry
//   valid bits cleared at once, so no clearing pass is needed. Not enforced by the
//   block: users must write cfg_write/cfg_index/cfg_data registers only when idle.
module ws2812_pwm_slot_encoder
  import wspwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: led_index[6:0], red[14:7], green[22:15], blue[30:23], finished_half[31]
  input  logic [31:0] s_axis_tdata,
  // tuser: operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: word_index[5:0], compare_value[21:6], zero fill[23:22]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  // Config registers
  logic [CMP_W-1:0]   pulse_high;
  logic [CMP_W-1:0]   pulse_low;
  logic [SCALE_W-1:0] brightness_scale;

  // Input field unpack
  logic [STORE_AW-1:0] in_led;
  logic [7:0]          in_red, in_green, in_blue;
  logic                in_half;

  assign in_led   = s_axis_tdata[6:0];
  assign in_red   = s_axis_tdata[14:7];
  assign in_green = s_axis_tdata[22:15];
  assign in_blue  = s_axis_tdata[30:23];
  assign in_half  = s_axis_tdata[31];

  // Frame position
  logic [SLOT_W-1:0] slot_counter;
  logic [SLOT_W-1:0] slot_counter_next;
  logic [SLOT_W-1:0] led_num;
  logic              slot_live;

  // Colour store valid bits: unwritten entries read as zero
  logic [STORE_DEPTH-1:0] colour_valid;
  logic [COLOUR_W-1:0]    ram_rd_data;

  // Fetch stage: fill waiting for its colour word
  logic              fetch_valid;
  logic [WORD_W-1:0] fetch_base;
  logic              fetch_live;
  logic              fetch_colour_ok;

  // Serializer / output register
  logic                out_valid;
  logic [WORD_W-1:0]   out_word;
  logic [CMP_W-1:0]    out_cmp;
  logic                out_last;
  logic [COLOUR_W-1:0] ser_bits;
  logic [COUNT_W-1:0]  ser_remaining;
  logic                ser_live;

  // Handshake
  logic colour_acc, fill_acc;
  logic out_done, ser_free, fetch_move, fill_ready;

  assign out_done   = out_valid && m_axis_tready && (ser_remaining == '0);
  assign ser_free   = !out_valid || out_done;
  assign fetch_move = fetch_valid && ser_free;
  assign fill_ready = !fetch_valid || fetch_move;

  assign s_axis_tready = !rst && ((s_axis_tuser == OP_COLOUR) || fill_ready);
  assign colour_acc    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_COLOUR);
  assign fill_acc      = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_FILL);

  // Slot N >= 2 sends LED N-2; wrap after the last LED
  assign led_num   = slot_counter - SLOT_W'(RESET_SLOTS);
  assign slot_live = slot_counter >= SLOT_W'(RESET_SLOTS);
  assign slot_counter_next =
    (slot_counter == SLOT_W'(LED_SLOTS + RESET_SLOTS - 1)) ? '0 : slot_counter + 1'b1;

  wspwm_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (STORE_DEPTH)
  ) u_colour_store (
    .clk     (clk),
    .wr_en   (colour_acc),
    .wr_addr (in_led),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (fill_acc),
    .rd_addr (led_num[STORE_AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Scale the fetched colour into the G,R,B bit order
  logic [COLOUR_W-1:0] load_colour;
  logic [COLOUR_W-1:0] load_bits;

  assign load_colour = fetch_colour_ok ? ram_rd_data : '0;
  assign load_bits   = {scale_channel(load_colour[15:8],  brightness_scale),
                        scale_channel(load_colour[23:16], brightness_scale),
                        scale_channel(load_colour[7:0],   brightness_scale)};

  function automatic logic [CMP_W-1:0] pick_word(input logic live, input logic bit_val,
                                                 input logic [CMP_W-1:0] hi,
                                                 input logic [CMP_W-1:0] lo);
    if (!live) begin
      return '0;
    end
    return bit_val ? hi : lo;
  endfunction

  // Config writes; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_high       <= CMP_W'(58);
      pulse_low        <= CMP_W'(29);
      brightness_scale <= SCALE_FULL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PULSE_HIGH: pulse_high       <= cfg_data;
        REG_PULSE_LOW:  pulse_low        <= cfg_data;
        REG_BRIGHTNESS: brightness_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Store valid bits and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      colour_valid <= '0;
      slot_counter <= '0;
    end else begin
      if (colour_acc) begin
        colour_valid[in_led] <= 1'b1;
      end
      if (fill_acc) begin
        slot_counter <= slot_counter_next;
      end
    end
  end

  // Fetch stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_valid <= 1'b0;
    end else if (fill_acc) begin
      fetch_valid <= 1'b1;
    end else if (fetch_move) begin
      fetch_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_acc) begin
      fetch_base      <= (in_half == 1'b0) ? WORD_W'(HALF_WORDS) : '0;
      fetch_live      <= slot_live;
      fetch_colour_ok <= slot_live && (led_num < SLOT_W'(STORE_DEPTH)) &&
                         colour_valid[led_num[STORE_AW-1:0]];
    end
  end

  // Serializer: load a fill, then shift one bit per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fetch_move) begin
      out_valid <= 1'b1;
    end else if (out_done) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_move) begin
      out_word      <= fetch_base;
      out_cmp       <= pick_word(fetch_live, load_bits[COLOUR_W-1], pulse_high, pulse_low);
      out_last      <= (HALF_WORDS == 1);
      ser_bits      <= {load_bits[COLOUR_W-2:0], 1'b0};
      ser_remaining <= COUNT_W'(HALF_WORDS - 1);
      ser_live      <= fetch_live;
    end else if (out_valid && m_axis_tready && (ser_remaining != '0)) begin
      out_word      <= out_word + 1'b1;
      out_cmp       <= pick_word(ser_live, ser_bits[COLOUR_W-1], pulse_high, pulse_low);
      out_last      <= (ser_remaining == COUNT_W'(1));
      ser_bits      <= {ser_bits[COLOUR_W-2:0], 1'b0};
      ser_remaining <= ser_remaining - 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_cmp, out_word};
  assign m_axis_tlast  = out_last;

endmodule
